### rtl/core/ins_frame_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the inertial frame deframer
// Concurrent checks clocked on clk, written one use per line.
// ----------------------------------------------------------------------------
`ifndef INS_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define INS_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define IFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ifd check failed");

// Next-cycle implication, evaluated during reset too.
`define IFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ifd check failed");

`endif

### rtl/core/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the inertial frame deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLES_LEN_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLES_LEN_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLES_LEN_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GNSS_LEN     = 2'd3;

  localparam logic [7:0] SYNC_FIRST  = 8'hFA;
  localparam logic [7:0] SYNC_SECOND = 8'hFF;

  localparam logic KIND_ANGLES = 1'b0;
  localparam logic KIND_GNSS   = 1'b1;

  typedef struct packed {
    logic [7:0] angles_len_a;
    logic [7:0] angles_len_b;
    logic [7:0] angles_len_c;
    logic [7:0] gnss_len;
  } cfg_t;

  typedef struct packed {
    logic       frame_kind;
    logic [8:0] byte_offset;
    logic [7:0] data_byte;
    logic [7:0] message_id;
    logic [7:0] frame_length;
    logic       is_last;
    logic [3:0] group_valid;
  } result_t;

endpackage

### rtl/core/ifd_channels.sv
// ----------------------------------------------------------------------------
// ifd channel interfaces
// Valid/ready channels for received bytes and deframed result items.
// ----------------------------------------------------------------------------
interface ifd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifd_result_if;
  logic       valid;
  logic       ready;
  logic       frame_kind;
  logic [8:0] byte_offset;
  logic [7:0] data_byte;
  logic [7:0] message_id;
  logic [7:0] frame_length;
  logic       is_last;
  logic [3:0] group_valid;

  modport source (output valid, output frame_kind, output byte_offset, output data_byte,
                  output message_id, output frame_length, output is_last,
                  output group_valid, input ready);
  modport sink   (input valid, input frame_kind, input byte_offset, input data_byte,
                  input message_id, input frame_length, input is_last,
                  input group_valid, output ready);
endinterface

### rtl/core/ins_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// ins_frame_deframer_unit
// Deframer for the binary inertial-sensor serial stream.
//
// Feed received bytes on rx, one request per byte. The unit hunts for the
// two sync bytes, captures the ID and length bytes, and emits one request on
// frame for every payload byte and for the checksum byte (is_last high).
// Lengths not set in the four length registers drop the frame. Angles frames
// report the four sub-block header checks in group_valid with the checksum.
// Sync, ID and length bytes produce no output.
// A payload byte accepted on rx passes the input register and the frame state
// machine into the result register, from which frame takes its request.
// Throughput: one byte per cycle while frame does not stall, set by the input
// and result registers around the frame state machine.
// Reset clears the state machine, the length registers and both registers'
// valid flags. When frame stalls, the result register holds, then the input
// register fills and rx.ready drops until frame takes the held result.
// Write cfg_* only while the unit has no byte in flight.
// ----------------------------------------------------------------------------
`include "ins_frame_deframer_unit_defines.svh"

module ins_frame_deframer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data,
  ifd_byte_if.sink                        rx,
  ifd_result_if.source                    frame
);

  ifd_pkg::cfg_t    cfg;
  ifd_pkg::result_t res;
  logic             res_valid;
  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             out_free;
  logic             advance;
  logic [8:0]       last_offset;
  logic             angles_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ifd_pkg::CFG_ANGLES_LEN_A: cfg.angles_len_a <= cfg_data;
        ifd_pkg::CFG_ANGLES_LEN_B: cfg.angles_len_b <= cfg_data;
        ifd_pkg::CFG_ANGLES_LEN_C: cfg.angles_len_c <= cfg_data;
        ifd_pkg::CFG_GNSS_LEN:     cfg.gnss_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = byte_valid && out_free;

  ifd_byte_reg u_byte_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  ifd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (advance),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  ifd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .out_free (out_free),
    .frame    (frame)
  );

  assign last_offset = {1'b0, frame.frame_length} + 9'd4;
  assign angles_last = frame.is_last && (frame.frame_kind == ifd_pkg::KIND_ANGLES);

  `IFD_ASSERT_NOW(a_last_offset, frame.valid && frame.is_last, frame.byte_offset == last_offset)
  `IFD_ASSERT_NOW(a_groups_on_last, frame.valid && (frame.group_valid != 4'd0), angles_last)
  `IFD_ASSERT_NOW(a_offset_range, frame.valid, (frame.byte_offset >= 9'd4) && (frame.byte_offset <= last_offset))
  `IFD_ASSERT_NEXT(a_reset_idle, rst, !frame.valid)

endmodule

### rtl/core/ifd_byte_reg.sv
// ----------------------------------------------------------------------------
// ifd_byte_reg
// Input register: captures one received byte and holds it until parsed.
// ----------------------------------------------------------------------------
module ifd_byte_reg (
  input  logic       clk,
  input  logic       rst,
  ifd_byte_if.sink   rx,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic take;

  assign rx.ready = !byte_valid || advance;
  assign take     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (take) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_data <= rx.rx_byte;
    end
  end

endmodule

### rtl/core/ifd_parser.sv
// ----------------------------------------------------------------------------
// ifd_parser
// Frame state machine: sync hunt, header capture, payload tagging and
// on-the-fly sub-block header checks for angles frames.
// ----------------------------------------------------------------------------
module ifd_parser (
  input  logic               clk,
  input  logic               rst,
  input  ifd_pkg::cfg_t      cfg,
  input  logic               step,
  input  logic [7:0]         byte_data,
  output logic               res_valid,
  output ifd_pkg::result_t   res
);

  localparam logic [2:0] ST_SYNC1 = 3'd0;
  localparam logic [2:0] ST_SYNC2 = 3'd1;
  localparam logic [2:0] ST_ID    = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;

  localparam logic [8:0] COUNT_START = 9'd1;
  localparam logic [8:0] OFFSET_BASE = 9'd3;

  // one match bit per header byte: euler [2:0], acc [4:3], gyro [6:5], baro [8:7]
  function automatic logic [8:0] header_hits(logic [8:0] off, logic [7:0] b);
    logic [8:0] h;
    h = '0;
    case (off)
      9'd4:    h[0] = (b == 8'h20);
      9'd5:    h[1] = (b == 8'h30);
      9'd6:    h[2] = (b == 8'h0C);
      9'd19:   h[3] = (b == 8'h40);
      9'd20:   h[4] = (b == 8'h30);
      9'd34:   h[5] = (b == 8'h80);
      9'd35:   h[6] = (b == 8'h20);
      9'd49:   h[7] = (b == 8'h30);
      9'd50:   h[8] = (b == 8'h10);
      default: h = '0;
    endcase
    return h;
  endfunction

  logic [2:0] state, state_next;
  logic [8:0] count, count_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] held_id, held_id_next;
  logic       held_kind, held_kind_next;
  logic [8:0] match, match_next;

  logic [8:0] last_count;
  logic [8:0] offset;
  logic       last;
  logic       len_angles;
  logic       len_gnss;

  assign last_count = {1'b0, held_length} + 9'd1;
  assign offset     = count + OFFSET_BASE;
  assign last       = (count == last_count);
  assign len_angles = (byte_data == cfg.angles_len_a) || (byte_data == cfg.angles_len_b) ||
                      (byte_data == cfg.angles_len_c);
  assign len_gnss   = (byte_data == cfg.gnss_len);

  always_comb begin
    state_next       = state;
    count_next       = count;
    held_length_next = held_length;
    held_id_next     = held_id;
    held_kind_next   = held_kind;
    match_next       = match;
    res_valid        = 1'b0;

    res.frame_kind   = held_kind;
    res.byte_offset  = offset;
    res.data_byte    = byte_data;
    res.message_id   = held_id;
    res.frame_length = held_length;
    res.is_last      = last;
    res.group_valid  = '0;

    unique case (state)
      ST_SYNC1: begin
        if (byte_data == ifd_pkg::SYNC_FIRST) state_next = ST_SYNC2;
      end
      ST_SYNC2: begin
        state_next = (byte_data == ifd_pkg::SYNC_SECOND) ? ST_ID : ST_SYNC1;
      end
      ST_ID: begin
        held_id_next = byte_data;
        state_next   = ST_LEN;
      end
      ST_LEN: begin
        held_length_next = byte_data;
        count_next       = COUNT_START;
        match_next       = '0;
        if (len_angles) begin
          held_kind_next = ifd_pkg::KIND_ANGLES;
          state_next     = ST_DATA;
        end else if (len_gnss) begin
          held_kind_next = ifd_pkg::KIND_GNSS;
          state_next     = ST_DATA;
        end else begin
          state_next = ST_SYNC1;
        end
      end
      ST_DATA: begin
        if (count > last_count) begin
          // drop a runaway count and hunt again
          state_next = ST_SYNC1;
          count_next = COUNT_START;
        end else begin
          match_next = match | header_hits(offset, byte_data);
          res_valid  = 1'b1;
          if (last && (held_kind == ifd_pkg::KIND_ANGLES)) begin
            res.group_valid = {&match_next[8:7], &match_next[6:5],
                               &match_next[4:3], &match_next[2:0]};
          end
          if (last) begin
            state_next = ST_SYNC1;
            count_next = COUNT_START;
          end else begin
            count_next = count + 9'd1;
          end
        end
      end
      default: begin
        state_next = ST_SYNC1;
        count_next = COUNT_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SYNC1;
      count       <= COUNT_START;
      held_length <= '0;
      held_id     <= '0;
      held_kind   <= ifd_pkg::KIND_ANGLES;
      match       <= '0;
    end else if (step) begin
      state       <= state_next;
      count       <= count_next;
      held_length <= held_length_next;
      held_id     <= held_id_next;
      held_kind   <= held_kind_next;
      match       <= match_next;
    end
  end

endmodule

### rtl/core/ifd_out_reg.sv
// ----------------------------------------------------------------------------
// ifd_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module ifd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ifd_pkg::result_t res,
  output logic             out_free,
  ifd_result_if.source     frame
);

  ifd_pkg::result_t held;

  assign out_free = !frame.valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (load) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign frame.frame_kind   = held.frame_kind;
  assign frame.byte_offset  = held.byte_offset;
  assign frame.data_byte    = held.data_byte;
  assign frame.message_id   = held.message_id;
  assign frame.frame_length = held.frame_length;
  assign frame.is_last      = held.is_last;
  assign frame.group_valid  = held.group_valid;

endmodule
